[rtl/core/rlp_pkg.sv]
// shared types, constants and method table for the request line parser
package rlp_pkg;

    localparam int METHOD_COUNT = 9;
    localparam int KNOWN_VERBS  = 9;
    localparam int VERB_NUM     = (METHOD_COUNT < KNOWN_VERBS) ? METHOD_COUNT : KNOWN_VERBS;
    localparam int PARSE_DEPTH  = 1024;
    localparam int LEN_W        = $clog2(PARSE_DEPTH + 1);
    localparam int CAP_W        = 11;
    localparam int BYTE_W       = 8;
    localparam int EVENT_W      = 4;
    localparam int METHOD_W     = 4;
    localparam int FAIL_W       = 2;
    localparam int OUT_DATA_W   = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

    typedef enum logic [2:0] {
        LS_NAME   = 3'd0,
        LS_PATH   = 3'd1,
        LS_PROTO  = 3'd2,
        LS_GOT_CR = 3'd3,
        LS_DONE   = 3'd4,
        LS_FAILED = 3'd5
    } line_state_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_METHOD_CHAR  = 4'd0,
        EV_METHOD_END   = 4'd1,
        EV_TARGET_CHAR  = 4'd2,
        EV_TARGET_END   = 4'd3,
        EV_VERSION_CHAR = 4'd4,
        EV_VERSION_END  = 4'd5,
        EV_WAIT         = 4'd6,
        EV_ERROR        = 4'd7,
        EV_PASSTHROUGH  = 4'd8
    } event_t;

    typedef enum logic [FAIL_W-1:0] {
        FAIL_NONE    = 2'd0,
        FAIL_BAD_REQ = 2'd1,
        FAIL_URI_LEN = 2'd2
    } fail_t;

    typedef struct packed {
        line_state_t         line;
        logic [LEN_W-1:0]    field_len;
        logic [VERB_NUM-1:0] cand;
        fail_t               fail;
    } parse_state_t;

    typedef struct packed {
        event_t              ev;
        logic [BYTE_W-1:0]   data;
        logic [METHOD_W-1:0] method;
        fail_t               fail;
    } parse_result_t;

    localparam logic [7:0] VERB_TEXT [KNOWN_VERBS][8] = '{
        '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
        '{"C", "O", "N", "N", "E", "C", "T", 8'h00},
        '{"O", "P", "T", "I", "O", "N", "S", 8'h00},
        '{"T", "R", "A", "C", "E", 8'h00, 8'h00, 8'h00},
        '{"P", "A", "T", "C", "H", 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] VERB_LEN [KNOWN_VERBS] = '{
        4'd3, 4'd4, 4'd4, 4'd3, 4'd6, 4'd7, 4'd7, 4'd5, 4'd5
    };

    localparam parse_state_t STATE_RESET = '{
        line:      LS_NAME,
        field_len: '0,
        cand:      '1,
        fail:      FAIL_NONE
    };

endpackage

[rtl/core/rlp_step.sv]
// per-byte next-state and result logic of the request line parser
module rlp_step
    import rlp_pkg::*;
(
    input  parse_state_t        state_in,
    input  logic [BYTE_W-1:0]   in_byte,
    input  logic                restart,
    input  logic [CAP_W-1:0]    url_capacity,
    output parse_state_t        state_next,
    output parse_result_t       result
);

    parse_state_t        cur;
    logic [BYTE_W-1:0]   upper;
    logic [BYTE_W-1:0]   lower;
    logic                is_alpha;
    logic                is_visible;
    logic                bad;
    logic                found;
    logic [LEN_W-1:0]    len_inc;

    always_comb begin
        cur        = restart ? STATE_RESET : state_in;
        is_alpha   = (in_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]});
        is_visible = (in_byte inside {[8'h21:8'h7E]});
        upper      = (in_byte inside {[8'h61:8'h7A]}) ? in_byte - 8'd32 : in_byte;
        lower      = (in_byte inside {[8'h41:8'h5A]}) ? in_byte + 8'd32 : in_byte;
        // saturating field counter
        len_inc    = (cur.field_len < LEN_W'(PARSE_DEPTH)) ? cur.field_len + 1'b1
                                                           : cur.field_len;
        state_next    = cur;
        result.ev     = EV_ERROR;
        result.data   = in_byte;
        result.method = '0;
        result.fail   = FAIL_NONE;
        bad           = 1'b0;
        found         = 1'b0;

        case (cur.line)
            LS_NAME: begin
                if (is_alpha) begin
                    result.data = upper;
                    result.ev   = EV_METHOD_CHAR;
                    for (int i = 0; i < VERB_NUM; i++) begin
                        if (cur.field_len >= LEN_W'(VERB_LEN[i]) ||
                            VERB_TEXT[i][cur.field_len[2:0]] != upper) begin
                            state_next.cand[i] = 1'b0;
                        end
                    end
                    state_next.field_len = len_inc;
                end else if (in_byte == 8'h20) begin
                    // first surviving candidate whose length matches exactly
                    for (int i = 0; i < VERB_NUM; i++) begin
                        if (!found && cur.cand[i] &&
                            cur.field_len == LEN_W'(VERB_LEN[i])) begin
                            result.method = METHOD_W'(i + 1);
                            found         = 1'b1;
                        end
                    end
                    state_next.line      = LS_PATH;
                    state_next.field_len = '0;
                    state_next.cand      = '1;
                    result.ev            = EV_METHOD_END;
                end else begin
                    bad = 1'b1;
                end
            end
            LS_PATH: begin
                if (in_byte == 8'h20) begin
                    result.ev = EV_TARGET_END;
                    if (32'(cur.field_len) >= 32'(url_capacity)) begin
                        state_next.fail = FAIL_URI_LEN;
                        state_next.line = LS_FAILED;
                        result.fail     = FAIL_URI_LEN;
                    end else begin
                        state_next.line = LS_PROTO;
                    end
                    state_next.field_len = '0;
                end else if (is_visible) begin
                    result.data          = lower;
                    result.ev            = EV_TARGET_CHAR;
                    state_next.field_len = len_inc;
                end else begin
                    bad = 1'b1;
                end
            end
            LS_PROTO: begin
                if (is_visible) begin
                    result.data          = upper;
                    result.ev            = EV_VERSION_CHAR;
                    state_next.field_len = len_inc;
                end else if (in_byte == 8'h0D) begin
                    state_next.line      = LS_GOT_CR;
                    state_next.field_len = '0;
                    result.ev            = EV_VERSION_END;
                end else if (in_byte == 8'h0A) begin
                    state_next.line      = LS_DONE;
                    state_next.field_len = '0;
                    result.ev            = EV_VERSION_END;
                end else begin
                    bad = 1'b1;
                end
            end
            LS_GOT_CR: begin
                if (in_byte == 8'h0A) begin
                    state_next.line = LS_DONE;
                    result.ev       = EV_WAIT;
                end else begin
                    bad = 1'b1;
                end
            end
            LS_DONE: begin
                result.ev = EV_PASSTHROUGH;
            end
            default: begin
                state_next.line = LS_FAILED;
                result.ev       = EV_ERROR;
                result.fail     = cur.fail;
            end
        endcase

        if (bad) begin
            state_next.fail = FAIL_BAD_REQ;
            state_next.line = LS_FAILED;
            result.ev       = EV_ERROR;
            result.fail     = FAIL_BAD_REQ;
            result.method   = '0;
        end
    end

endmodule

[rtl/core/http_request_line_parser_unit.sv]
// top level of the http request line parser
// Byte-stream parser for the first line of an http request.
// Input channel s_*: one raw byte per transfer in s_tdata, s_tuser set
// returns the parser to the method state before that byte is handled.
// Output channel m_*: exactly one result per input byte, in order. m_tuser
// carries the event code, m_tdata the case-folded byte, method number and
// failure code.
// Path: an accepted byte sits in the input register, and its result is then
// registered in the result register and shown on m_tvalid. Throughput: one byte
// per cycle while m_tready allows, with the state update between the two registers.
// The input register keeps accepting while a result waits, as long as the
// result register can drain into the sink in the same cycle.
// When the receiver holds m_tready low, the result stays put, one more byte
// is held in the input register and then s_tready drops.
// Reset (aresetn low, synchronous) empties both registers, puts the parser
// in the method state and sets the target capacity to 1024.
// cfg_we writes cfg_wdata into the target capacity; write only while idle.
module http_request_line_parser_unit
    import rlp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CAP_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,    // [7:0] in_byte
    input  logic                  s_tuser,    // [0] restart
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,    // [7:0] out_byte, [11:8] method_id,
                                              // [13:12] fail_code, [15:14] zero
    output logic [EVENT_W-1:0]    m_tuser     // [3:0] event_code
);

    logic                in_valid_reg;
    logic [BYTE_W-1:0]   in_byte_reg;
    logic                in_restart_reg;
    parse_state_t        state_reg;
    parse_state_t        state_next;
    parse_result_t       result_next;
    parse_result_t       result_reg;
    logic                out_valid_reg;
    logic [CAP_W-1:0]    capacity_reg;
    logic                advance;

    rlp_step u_step (
        .state_in     (state_reg),
        .in_byte      (in_byte_reg),
        .restart      (in_restart_reg),
        .url_capacity (capacity_reg),
        .state_next   (state_next),
        .result       (result_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
            capacity_reg  <= CAP_RESET;
        end else begin
            if (cfg_we) begin
                capacity_reg <= cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg    <= s_tdata;
            in_restart_reg <= s_tuser;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, result_reg.fail, result_reg.method, result_reg.data};
    assign m_tuser  = result_reg.ev;

endmodule
